>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the text field checker.
// ----------------------------------------------------------------------------
// Each macro samples on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tfu8_pkg.sv
// ----------------------------------------------------------------------------
// tfu8_pkg
// Types and constants shared by the text field UTF-8 checker modules.
// ----------------------------------------------------------------------------
package tfu8_pkg;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_UNTERM = 3'd1,
      ERR_LONG   = 3'd2,
      ERR_CTRL   = 3'd3,
      ERR_LEAD   = 3'd4,
      ERR_TRUNC  = 3'd5,
      ERR_CONT   = 3'd6
   } err_type;

   typedef enum logic [2:0] {
      CLS_ASCII = 3'd0,
      CLS_CTRL  = 3'd1,
      CLS_LEAD2 = 3'd2,
      CLS_LEAD3 = 3'd3,
      CLS_LEAD4 = 3'd4,
      CLS_BAD   = 3'd5
   } char_cls_type;

   typedef struct packed {
      logic         last;
      logic         zero;
      logic         cont_ok;
      char_cls_type cls;
   } item_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;
   localparam logic [7:0] HIGH_BIT   = 8'h80;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] DEL_CHAR   = 8'h7F;
   localparam logic [7:0] NL_CHAR    = 8'h0A;
   localparam logic [7:0] TAB_CHAR   = 8'h09;

endpackage

>>> rtl/tfu8_front.sv
// ----------------------------------------------------------------------------
// tfu8_front
// Accepts field bytes and classifies each one for the back end.
// ----------------------------------------------------------------------------
module tfu8_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_byte_value,
   input  logic               req_last_byte,
   output logic               push_valid,
   input  logic               push_ready,
   output tfu8_pkg::item_type push_item
);

   tfu8_pkg::char_cls_type cls;

   always_comb begin
      if (((req_byte_value < tfu8_pkg::SPACE_CHAR) && (req_byte_value != tfu8_pkg::NL_CHAR)
           && (req_byte_value != tfu8_pkg::TAB_CHAR)) || (req_byte_value == tfu8_pkg::DEL_CHAR))
      begin
         cls = tfu8_pkg::CLS_CTRL;
      end else if ((req_byte_value & tfu8_pkg::HIGH_BIT) == 8'h00) begin
         cls = tfu8_pkg::CLS_ASCII;
      end else if ((req_byte_value & tfu8_pkg::LEAD2_MASK) == tfu8_pkg::LEAD2_TAG) begin
         cls = tfu8_pkg::CLS_LEAD2;
      end else if ((req_byte_value & tfu8_pkg::LEAD3_MASK) == tfu8_pkg::LEAD3_TAG) begin
         cls = tfu8_pkg::CLS_LEAD3;
      end else if ((req_byte_value & tfu8_pkg::LEAD4_MASK) == tfu8_pkg::LEAD4_TAG) begin
         cls = tfu8_pkg::CLS_LEAD4;
      end else begin
         cls = tfu8_pkg::CLS_BAD;
      end
   end

   assign req_ready         = push_ready;
   assign push_valid        = req_valid;
   assign push_item.last    = req_last_byte;
   assign push_item.zero    = (req_byte_value == 8'h00);
   assign push_item.cont_ok = ((req_byte_value & tfu8_pkg::CONT_MASK) == tfu8_pkg::CONT_TAG);
   assign push_item.cls     = cls;

endmodule

>>> rtl/tfu8_queue.sv
// ----------------------------------------------------------------------------
// tfu8_queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module tfu8_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tfu8_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tfu8_pkg::item_type pop_item,
   output logic [tfu8_pkg::QCNT_BITS-1:0] level
);

   tfu8_pkg::item_type                   ent_ff [tfu8_pkg::QUEUE_DEPTH];
   logic [tfu8_pkg::QPTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tfu8_pkg::QPTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tfu8_pkg::QCNT_BITS-1:0]       count_ff, count_in;
   logic                                 push, pop;

   assign push_ready = (count_ff != tfu8_pkg::QCNT_BITS'(tfu8_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = ent_ff[rd_ptr_ff];
   assign level      = count_ff;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/tfu8_back.sv
// ----------------------------------------------------------------------------
// tfu8_back
// Per-field state update and the registered result stage.
// ----------------------------------------------------------------------------
module tfu8_back #(
   parameter int LENGTH_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [15:0]        csr_data,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  tfu8_pkg::item_type pop_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_valid_res,
   output logic [2:0]         rsp_error_code
);

   logic [LENGTH_BITS-1:0] max_len_ff, max_len_in;
   logic                   seen_ff, seen_in;
   logic [LENGTH_BITS:0]   len_ff, len_in;
   logic [1:0]             pend_ff, pend_in;
   tfu8_pkg::err_type      cerr_ff, cerr_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   res_ff, res_in;
   tfu8_pkg::err_type      code_ff, code_in;
   logic                   take;
   logic [LENGTH_BITS:0]   len_upd;
   logic [1:0]             pend_upd;
   tfu8_pkg::err_type      cerr_upd;
   logic                   seen_upd;
   tfu8_pkg::err_type      code;

   // Stall a final item only while the held result is not being taken.
   assign pop_ready = !pop_item.last || !out_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;

   assign max_len_in = csr_we ? LENGTH_BITS'(csr_data) : max_len_ff;

   always_comb begin
      seen_upd = seen_ff;
      len_upd  = len_ff;
      pend_upd = pend_ff;
      cerr_upd = cerr_ff;
      if (!seen_ff) begin
         if (pop_item.zero) begin
            seen_upd = 1'b1;
            if ((pend_ff != 2'd0) &&
                ((cerr_ff == tfu8_pkg::ERR_NONE) || (cerr_ff == tfu8_pkg::ERR_CONT))) begin
               cerr_upd = tfu8_pkg::ERR_TRUNC;
            end
            pend_upd = 2'd0;
         end else begin
            // Saturate once the top bit is set.
            if (!len_ff[LENGTH_BITS]) begin
               len_upd = len_ff + 1'b1;
            end
            if (pend_ff != 2'd0) begin
               if ((cerr_ff == tfu8_pkg::ERR_NONE) && !pop_item.cont_ok) begin
                  cerr_upd = tfu8_pkg::ERR_CONT;
               end
               pend_upd = pend_ff - 2'd1;
            end else if (cerr_ff == tfu8_pkg::ERR_NONE) begin
               case (pop_item.cls)
                  tfu8_pkg::CLS_ASCII: pend_upd = 2'd0;
                  tfu8_pkg::CLS_CTRL:  cerr_upd = tfu8_pkg::ERR_CTRL;
                  tfu8_pkg::CLS_LEAD2: pend_upd = 2'd1;
                  tfu8_pkg::CLS_LEAD3: pend_upd = 2'd2;
                  tfu8_pkg::CLS_LEAD4: pend_upd = 2'd3;
                  tfu8_pkg::CLS_BAD:   cerr_upd = tfu8_pkg::ERR_LEAD;
                  default:             cerr_upd = tfu8_pkg::ERR_LEAD;
               endcase
            end
         end
      end

      if (!pop_item.zero) begin
         code = tfu8_pkg::ERR_UNTERM;
      end else if (len_upd > {1'b0, max_len_ff}) begin
         code = tfu8_pkg::ERR_LONG;
      end else begin
         code = cerr_upd;
      end

      seen_in      = seen_ff;
      len_in       = len_ff;
      pend_in      = pend_ff;
      cerr_in      = cerr_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      res_in       = res_ff;
      code_in      = code_ff;
      if (take) begin
         if (pop_item.last) begin
            // Clear the field state and load the result.
            seen_in      = 1'b0;
            len_in       = '0;
            pend_in      = 2'd0;
            cerr_in      = tfu8_pkg::ERR_NONE;
            out_valid_in = 1'b1;
            res_in       = (code == tfu8_pkg::ERR_NONE);
            code_in      = code;
         end else begin
            seen_in = seen_upd;
            len_in  = len_upd;
            pend_in = pend_upd;
            cerr_in = cerr_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= LENGTH_BITS'(255);
         seen_ff      <= 1'b0;
         len_ff       <= '0;
         pend_ff      <= 2'd0;
         cerr_ff      <= tfu8_pkg::ERR_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         seen_ff      <= seen_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         cerr_ff      <= cerr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      code_ff <= code_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_valid_res  = res_ff;
   assign rsp_error_code = code_ff;

endmodule

>>> rtl/text_field_utf8_checker.sv
// ----------------------------------------------------------------------------
// text_field_utf8_checker
// Streaming UTF-8 and length check of a fixed-size, zero-terminated text field.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one field byte per item, req_last_byte marks the final byte.
//   rsp_*  : one result item per field, issued for the final byte only:
//            rsp_valid_res and rsp_error_code (0 ok, 1 unterminated,
//            2 too long, 3 control, 4 bad lead, 5 truncated, 6 bad continuation).
//   csr_*  : write of max_length, always ready; write only while idle.
// Throughput is one byte per cycle while no final byte is stalled. The front
// end classifies the byte and pushes it into a two-entry queue; the back end
// updates the field state from the queue head, one item a cycle unless stalled.
// A final byte is held in a queue entry and its result is then loaded into the
// output register; each item ahead of it in the queue delays that result.
// The result sits in an output register; further bytes keep flowing while
// it waits. A final byte waits in the queue while an earlier result is still
// held, and req_ready drops once both queue entries are taken.
// Reset clears the field state and the queue and sets max_length to 255.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_field_utf8_checker #(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_res,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_length
);

   logic                                 push_valid, push_ready;
   tfu8_pkg::item_type                   push_item;
   logic                                 pop_valid, pop_ready;
   tfu8_pkg::item_type                   pop_item;
   logic [tfu8_pkg::QCNT_BITS-1:0]       q_level;

   assign csr_ready = 1'b1;

   tfu8_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   tfu8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .level      (q_level)
   );

   tfu8_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_valid && csr_ready),
      .csr_data       (csr_max_length),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_error_code (rsp_error_code)
   );

   `ASSERT_SAME(a_res_matches_code, rsp_valid,
      rsp_valid_res == (rsp_error_code == tfu8_pkg::ERR_NONE),
      "result flag disagrees with error code")

   `ASSERT_NEXT(a_last_gives_result, pop_valid && pop_ready && pop_item.last,
      rsp_valid, "final item taken but no result held")

   `ASSERT_SAME(a_stall_only_when_full, !req_ready,
      q_level == tfu8_pkg::QCNT_BITS'(tfu8_pkg::QUEUE_DEPTH),
      "input stalled while queue has room")

endmodule
